// ===== hw/rtl/dms_pkg.sv =====
// Shared constants, types and the morphism index function for the dictionary match search.
package dms_pkg;

	localparam int MAX_ATOMS  = 64;
	localparam int SIDE       = 4;
	localparam int CELLS      = SIDE * SIDE;
	localparam int ATOM_DEPTH = MAX_ATOMS * CELLS;

	localparam int ATOM_W   = $clog2(MAX_ATOMS);
	localparam int IDX_W    = $clog2(SIDE);
	localparam int ELEM_W   = $clog2(CELLS);
	localparam int ADDR_W   = $clog2(ATOM_DEPTH);
	localparam int VAL_W    = 16;
	localparam int COUNT_W  = 7;
	localparam int MORPH_W  = 5;
	localparam int OPS_W    = 3;
	localparam int OPS      = 2 ** OPS_W;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_W    = PROD_W + ELEM_W;
	localparam int PROJ_W   = 17;
	localparam int FRAC_SH  = 14;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_ATOMS);
	localparam logic [PROJ_W-1:0]  PROJ_MAX  = {PROJ_W{1'b1}};
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_SH - 1));
	localparam logic signed [ACC_W-1:0] BEST_INIT  = -(ACC_W'(2 ** 19));

	// Opcode of an input transaction.
	localparam logic OP_ATOM   = 1'b0;
	localparam logic OP_TARGET = 1'b1;

	// Issue-side control that travels alongside the operands into the MAC.
	typedef struct packed {
		logic              v;
		logic              first;
		logic              last;
		logic [OPS_W-1:0]  op;
		logic [ATOM_W-1:0] atom;
	} mac_ctl_t;

	// Finished dot product and pipeline occupancy reported by the MAC.
	typedef struct packed {
		logic                     busy;
		logic                     v;
		logic [OPS_W-1:0]         op;
		logic [ATOM_W-1:0]        atom;
		logic signed [ACC_W-1:0]  sum;
	} mac_res_t;

	// Atom element that lands on target position pos under geometric morphism op.
	function automatic logic [ELEM_W-1:0] src_index(input logic [OPS_W-1:0] op,
			input logic [ELEM_W-1:0] pos);
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] sr;
		logic [IDX_W-1:0] sc;
		r  = pos[ELEM_W-1:IDX_W];
		c  = pos[IDX_W-1:0];
		sr = op[2] ? IDX_W'(SIDE - 1) - r : r;
		sc = op[1] ? IDX_W'(SIDE - 1) - c : c;
		if (op[0]) begin
			return {sc, sr};
		end
		return {sr, sc};
	endfunction

endpackage

// ===== hw/rtl/dms_mac.sv =====
// Multiply-accumulate pipeline that forms one 16-term dot product per morphism.
module dms_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dms_pkg::mac_ctl_t                 ctl_s1,
	input  logic signed [dms_pkg::VAL_W-1:0]  atom_s1,
	input  logic signed [dms_pkg::VAL_W-1:0]  tgt_s1,
	output dms_pkg::mac_res_t                 res
);

	dms_pkg::mac_ctl_t                    ctl_s2;
	logic signed [dms_pkg::PROD_W-1:0]    prod_s2;
	logic signed [dms_pkg::ACC_W-1:0]     acc_q;
	logic signed [dms_pkg::ACC_W-1:0]     sum_next;
	logic                                 res_v_q;
	logic [dms_pkg::OPS_W-1:0]            res_op_q;
	logic [dms_pkg::ATOM_W-1:0]           res_atom_q;
	logic signed [dms_pkg::ACC_W-1:0]     res_sum_q;

	assign sum_next = (ctl_s2.first ? '0 : acc_q) + dms_pkg::ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			res_v_q <= 1'b0;
		end else begin
			ctl_s2  <= ctl_s1;
			res_v_q <= ctl_s2.v && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= atom_s1 * tgt_s1;
		if (ctl_s2.v) begin
			acc_q <= sum_next;
		end
		if (ctl_s2.v && ctl_s2.last) begin
			res_sum_q  <= sum_next;
			res_op_q   <= ctl_s2.op;
			res_atom_q <= ctl_s2.atom;
		end
	end

	assign res.busy = ctl_s2.v;
	assign res.v    = res_v_q;
	assign res.op   = res_op_q;
	assign res.atom = res_atom_q;
	assign res.sum  = res_sum_q;

endmodule

// ===== hw/rtl/dictionary_match_search_core.sv =====
// Top level of the dictionary match search: atom store, target, scan control and result.
//
// The block holds up to 64 atoms of 4x4 Q1.14 coefficients in a 1024-entry two-port
// synchronous memory and one 4x4 Q12.4 target in registers. An input transaction with
// opcode 0 writes one atom element; opcode 1 writes one target element, and when last
// is set it also starts a search over atoms 0..atom_count-1 (values above 64 count as
// 64) and all 32 morphism codes. Every morphism is a transpose / row reverse / column
// reverse combination, optionally negated, and bit 3 of the code changes nothing, so
// only eight dot products per atom are really computed: one element product per cycle
// on the single multiplier, with the atom element fetched from memory at the morphed
// address. An atom therefore issues its element products, then drains the MAC pipeline
// and then weighs the negated variants in code order; an empty search goes straight to
// the done state, which loads its result into the output register once that is free.
// Ties go to the first code found. The projection is the best sum rounded to Q12.4,
// zero when the best sum is not positive, and saturated at 131071. Writes that do not
// start a search leave in_ready high. in_ready is low for the duration of a search;
// the finished result sits in an output register, so new transactions are taken while
// it waits to be collected. atom_count may only be written while the block is idle.
// Memory contents are not cleared by reset, so an atom or target element must be
// written before a search that uses it.
module dictionary_match_search_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dms_pkg::COUNT_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [dms_pkg::ATOM_W-1:0]          atom_slot,
	input  logic [dms_pkg::ELEM_W-1:0]          element,
	input  logic signed [dms_pkg::VAL_W-1:0]    value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dms_pkg::ATOM_W-1:0]          best_atom,
	output logic [dms_pkg::MORPH_W-1:0]         best_morphism,
	output logic [dms_pkg::PROJ_W-1:0]          projection
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_NEG,
		ST_DONE
	} state_t;

	localparam int FRAC_SH_L = dms_pkg::FRAC_SH;

	state_t                                state_q;
	logic [dms_pkg::COUNT_W-1:0]           atom_count_q;
	logic [dms_pkg::COUNT_W-1:0]           count_q;
	logic [dms_pkg::ATOM_W-1:0]            atom_q;
	logic [dms_pkg::OPS_W-1:0]             op_q;
	logic [dms_pkg::ELEM_W-1:0]            pos_q;
	logic [dms_pkg::OPS_W-1:0]             k_q;
	logic signed [dms_pkg::ACC_W-1:0]      best_q;
	logic [dms_pkg::ATOM_W-1:0]            best_atom_q;
	logic [dms_pkg::MORPH_W-1:0]           best_morph_q;
	logic                                  out_valid_q;
	logic [dms_pkg::ATOM_W-1:0]            out_atom_q;
	logic [dms_pkg::MORPH_W-1:0]           out_morph_q;
	logic [dms_pkg::PROJ_W-1:0]            out_proj_q;

	// Atom store and target registers.
	logic signed [dms_pkg::VAL_W-1:0]      atom_mem [dms_pkg::ATOM_DEPTH];
	logic signed [dms_pkg::VAL_W-1:0]      target_q [dms_pkg::CELLS];
	logic signed [dms_pkg::VAL_W-1:0]      atom_s1;
	logic signed [dms_pkg::VAL_W-1:0]      tgt_s1;
	dms_pkg::mac_ctl_t                     ctl_s1;
	dms_pkg::mac_res_t                     res;

	// Eight stored positive sums of the current atom, replayed negated afterwards.
	logic signed [dms_pkg::ACC_W-1:0]      sums_q [dms_pkg::OPS];

	logic                                  accept;
	logic                                  start;
	logic                                  issue;
	logic [dms_pkg::ADDR_W-1:0]            wr_addr;
	logic [dms_pkg::ADDR_W-1:0]            rd_addr;
	logic signed [dms_pkg::ACC_W-1:0]      res_sum;
	logic signed [dms_pkg::ACC_W-1:0]      neg_sum;
	logic signed [dms_pkg::ACC_W-1:0]      rounded;
	logic [dms_pkg::ACC_W-FRAC_SH_L-1:0]   scaled;
	logic [dms_pkg::PROJ_W-1:0]            proj_next;
	logic [dms_pkg::COUNT_W-1:0]           count_eff;
	logic                                  last_atom;
	logic                                  out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign start    = accept && (opcode == dms_pkg::OP_TARGET) && last;
	assign issue    = (state_q == ST_RUN);
	assign wr_addr  = {atom_slot, element};
	assign rd_addr  = {atom_q, dms_pkg::src_index(op_q, pos_q)};
	assign count_eff = (atom_count_q > dms_pkg::COUNT_MAX) ? dms_pkg::COUNT_MAX : atom_count_q;
	assign last_atom = ({1'b0, atom_q} == count_q - dms_pkg::COUNT_W'(1));
	assign out_free  = !out_valid_q || out_ready;

	assign res_sum = res.sum;
	assign neg_sum = -sums_q[k_q];

	// Round to Q12.4 and saturate; a best sum that is not positive gives zero.
	assign rounded = best_q + dms_pkg::ROUND_HALF;
	assign scaled  = rounded[dms_pkg::ACC_W-1:FRAC_SH_L];
	always_comb begin
		if (best_q <= 0) begin
			proj_next = '0;
		end else if (|scaled[$bits(scaled)-1:dms_pkg::PROJ_W]) begin
			proj_next = dms_pkg::PROJ_MAX;
		end else begin
			proj_next = scaled[dms_pkg::PROJ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= '0;
		end else if (cfg_we) begin
			atom_count_q <= cfg_wdata;
		end
	end

	// Atom memory: one write port for loading, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (accept && (opcode == dms_pkg::OP_ATOM)) begin
			atom_mem[wr_addr] <= value;
		end
		atom_s1 <= atom_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && (opcode == dms_pkg::OP_TARGET)) begin
			target_q[element] <= value;
		end
		tgt_s1 <= target_q[pos_q];
		if (res.v) begin
			sums_q[res.op] <= res_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.v     <= issue;
			ctl_s1.first <= (pos_q == '0);
			ctl_s1.last  <= (pos_q == dms_pkg::ELEM_W'(dms_pkg::CELLS - 1));
			ctl_s1.op    <= op_q;
			ctl_s1.atom  <= atom_q;
		end
	end

	dms_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.atom_s1(atom_s1),
		.tgt_s1 (tgt_s1),
		.res    (res)
	);

	// Scan sequencer, running best and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			atom_q       <= '0;
			op_q         <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			best_q       <= dms_pkg::BEST_INIT;
			best_atom_q  <= '0;
			best_morph_q <= '0;
			out_valid_q  <= 1'b0;
			out_atom_q   <= '0;
			out_morph_q  <= '0;
			out_proj_q   <= '0;
		end else begin
			// In ST_DONE the output register is reloaded instead when it is taken.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			// Positive variants are judged as their sums come out of the MAC, in code order.
			if (res.v && (res_sum > best_q)) begin
				best_q       <= res_sum;
				best_atom_q  <= res.atom;
				best_morph_q <= {2'b00, res.op};
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q      <= count_eff;
						atom_q       <= '0;
						op_q         <= '0;
						pos_q        <= '0;
						best_q       <= dms_pkg::BEST_INIT;
						best_atom_q  <= '0;
						best_morph_q <= '0;
						state_q      <= (count_eff == '0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					pos_q <= pos_q + dms_pkg::ELEM_W'(1);
					if (pos_q == dms_pkg::ELEM_W'(dms_pkg::CELLS - 1)) begin
						op_q <= op_q + dms_pkg::OPS_W'(1);
						if (op_q == dms_pkg::OPS_W'(dms_pkg::OPS - 1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.v && !res.busy && !res.v) begin
						k_q     <= '0;
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					// Negated variants carry code 16 + k and follow every positive one.
					if (neg_sum > best_q) begin
						best_q       <= neg_sum;
						best_atom_q  <= atom_q;
						best_morph_q <= {2'b10, k_q};
					end
					k_q <= k_q + dms_pkg::OPS_W'(1);
					if (k_q == dms_pkg::OPS_W'(dms_pkg::OPS - 1)) begin
						if (last_atom) begin
							state_q <= ST_DONE;
						end else begin
							atom_q  <= atom_q + dms_pkg::ATOM_W'(1);
							op_q    <= '0;
							pos_q   <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_atom_q  <= best_atom_q;
						out_morph_q <= best_morph_q;
						out_proj_q  <= proj_next;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign best_atom     = out_atom_q;
	assign best_morphism = out_morph_q;
	assign projection    = out_proj_q;

	// A morphism with bit 3 set never beats the equal code without it.
	a_no_bit3_winner: assert property (@(posedge clk) disable iff (!arst_n)
		!best_morph_q[3])
		else $error("winning morphism has bit 3 set");

	// The scan never addresses an atom at or beyond the latched count.
	a_atom_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ({1'b0, atom_q} < count_q))
		else $error("scan atom index beyond atom count");

	// Finished sums only appear while the scan of an atom is in flight.
	a_sum_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res.v |-> ((state_q == ST_RUN) || (state_q == ST_DRAIN)))
		else $error("MAC result outside of a scan");

	// The negated replay only starts once the MAC pipeline is empty.
	a_neg_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEG) |-> (!ctl_s1.v && !res.busy && !res.v))
		else $error("negated pass overlaps MAC activity");

	// A result is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_proj_q)))
		else $error("pending result overwritten");

endmodule

// ===== tb/tb_dictionary_match_search_core.sv =====
// Self-checking testbench for the dictionary match search core with its scoreboard class.
`timescale 1ns / 1ps

class match_board;
	typedef struct packed {
		logic [dms_pkg::ATOM_W-1:0]  atom;
		logic [dms_pkg::MORPH_W-1:0] morph;
		logic [dms_pkg::PROJ_W-1:0]  proj;
	} match_t;

	logic signed [dms_pkg::VAL_W-1:0] atoms[dms_pkg::ATOM_DEPTH];
	logic signed [dms_pkg::VAL_W-1:0] target[dms_pkg::CELLS];
	logic [dms_pkg::COUNT_W-1:0]      atom_count;
	match_t                           pending[$];
	int                               mismatches;

	function new();
		atom_count = '0;
		mismatches = 0;
	endfunction

	function void set_count(input logic [dms_pkg::COUNT_W-1:0] v);
		atom_count = v;
	endfunction

	function int depth();
		return pending.size();
	endfunction

	// Exhaustive search over every atom and every code, strictly greater wins.
	function match_t predict_match();
		match_t res;
		int     n;
		int     sr;
		int     sc;
		int     swap;
		longint best;
		longint acc;
		longint w;
		longint rounded;
		n = (atom_count > dms_pkg::MAX_ATOMS) ? dms_pkg::MAX_ATOMS : int'(atom_count);
		best = -(longint'(2) << 18);
		res = '0;
		for (int a = 0; a < n; a++) begin
			for (int m = 0; m < 32; m++) begin
				acc = 0;
				for (int r = 0; r < dms_pkg::SIDE; r++) begin
					for (int c = 0; c < dms_pkg::SIDE; c++) begin
						sr = m[2] ? (dms_pkg::SIDE - 1) - r : r;
						sc = m[1] ? (dms_pkg::SIDE - 1) - c : c;
						if (m[0]) begin
							swap = sr;
							sr = sc;
							sc = swap;
						end
						w = atoms[a * dms_pkg::CELLS + sr * dms_pkg::SIDE + sc];
						if (m[4]) begin
							w = -w;
						end
						acc += w * longint'(target[r * dms_pkg::SIDE + c]);
					end
				end
				if (acc > best) begin
					best = acc;
					res.atom = a[dms_pkg::ATOM_W-1:0];
					res.morph = m[dms_pkg::MORPH_W-1:0];
				end
			end
		end
		if (best > 0) begin
			rounded = (best + 8192) >>> 14;
			res.proj = (rounded > 131071) ? dms_pkg::PROJ_MAX : rounded[dms_pkg::PROJ_W-1:0];
		end
		return res;
	endfunction

	function void note_input(input logic op, input logic [dms_pkg::ATOM_W-1:0] slot,
			input logic [dms_pkg::ELEM_W-1:0] elem, input logic signed [dms_pkg::VAL_W-1:0] val,
			input logic lst);
		if (op == dms_pkg::OP_ATOM) begin
			atoms[int'(slot) * dms_pkg::CELLS + int'(elem)] = val;
			return;
		end
		target[elem] = val;
		if (lst) begin
			pending = {pending, predict_match()};
		end
	endfunction

	function void check_result(input logic [dms_pkg::ATOM_W-1:0] a,
			input logic [dms_pkg::MORPH_W-1:0] m, input logic [dms_pkg::PROJ_W-1:0] p);
		match_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result, expected none, got atom %0d morphism %0d %s %0d",
				$time, a, m, "projection", p);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		if (a !== want.atom) begin
			$display("%0t: best_atom expected %0d, got %0d", $time, want.atom, a);
			mismatches++;
		end
		if (m !== want.morph) begin
			$display("%0t: best_morphism expected %0d, got %0d", $time, want.morph, m);
			mismatches++;
		end
		if (p !== want.proj) begin
			$display("%0t: projection expected %0d, got %0d", $time, want.proj, p);
			mismatches++;
		end
	endfunction
endclass

module tb_dictionary_match_search_core;

	// Hang guard only; a correct run finishes far below this.
	localparam int CYCLE_LIMIT = 10_000_000;

	// Value styles used to fill atoms and targets.
	typedef enum int {FILL_FULL, FILL_ZERO, FILL_SMALL, FILL_EDGE} fill_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [dms_pkg::COUNT_W-1:0]         cfg_wdata = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic                                opcode = dms_pkg::OP_ATOM;
	logic [dms_pkg::ATOM_W-1:0]          atom_slot = '0;
	logic [dms_pkg::ELEM_W-1:0]          element = '0;
	logic signed [dms_pkg::VAL_W-1:0]    value = '0;
	logic                                last = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [dms_pkg::ATOM_W-1:0]          best_atom;
	logic [dms_pkg::MORPH_W-1:0]         best_morphism;
	logic [dms_pkg::PROJ_W-1:0]          projection;

	match_board board = new();
	int         cycle_count = 0;
	int         sent = 0;
	// When set, neither side inserts idle or stall cycles.
	logic       quiet = 1'b0;

	dictionary_match_search_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.atom_slot     (atom_slot),
		.element       (element),
		.value         (value),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.best_atom     (best_atom),
		.best_morphism (best_morphism),
		.projection    (projection)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Timeout: if the run ever stalls, this is the only way out.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result monitor. Sampling right after the edge sees the values that were
	// present at the edge, since every driver on either side updates with NBAs.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(best_atom, best_morphism, projection);
		end
	end

	// Receiver back-pressure: random runs of ready broken by random stall bursts,
	// and a permanently ready receiver once the quiet phase starts.
	initial begin
		int run_len;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				run_len = $urandom_range(1, 14);
				out_ready <= 1'b0;
			end else begin
				run_len = $urandom_range(1, 20);
				out_ready <= 1'b1;
			end
			repeat (run_len - 1) @(posedge clk);
		end
	end

	function automatic fill_t pick_fill();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return FILL_FULL;
		end
		if (roll < 60) begin
			return FILL_ZERO;
		end
		if (roll < 80) begin
			return FILL_SMALL;
		end
		return FILL_EDGE;
	endfunction

	function automatic logic signed [dms_pkg::VAL_W-1:0] fill_value(input fill_t style);
		logic signed [dms_pkg::VAL_W-1:0] v;
		case (style)
			FILL_ZERO: begin
				v = '0;
			end
			FILL_SMALL: begin
				v = dms_pkg::VAL_W'($urandom_range(0, 16)) - dms_pkg::VAL_W'(8);
			end
			FILL_EDGE: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh8000;
					1: v = 16'sh7FFF;
					2: v = -16'sd1;
					default: v = 16'sd1;
				endcase
			end
			default: begin
				v = dms_pkg::VAL_W'($urandom);
			end
		endcase
		return v;
	endfunction

	// Presents one transaction, possibly after an idle burst, and holds it
	// until the block takes it. Called just after a rising edge.
	task automatic send_item(input logic op, input logic [dms_pkg::ATOM_W-1:0] slot,
			input logic [dms_pkg::ELEM_W-1:0] elem, input logic signed [dms_pkg::VAL_W-1:0] val,
			input logic lst);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		atom_slot <= slot;
		element   <= elem;
		value     <= val;
		last      <= lst;
		do begin
			@(posedge clk);
		end while (!in_ready);
		board.note_input(op, slot, elem, val, lst);
		sent++;
	endtask

	// Drops valid, waits for every outstanding search result, and then lets the
	// clock run on so the block is certainly idle before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.depth() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic [dms_pkg::COUNT_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_count(v);
	endtask

	// A complete target, element order shuffled, with last on the final write.
	task automatic send_full_target();
		int    order[dms_pkg::CELLS];
		int    j;
		int    hold;
		fill_t style;
		for (int i = 0; i < dms_pkg::CELLS; i++) begin
			order[i] = i;
		end
		for (int i = dms_pkg::CELLS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			hold = order[i];
			order[i] = order[j];
			order[j] = hold;
		end
		style = pick_fill();
		for (int i = 0; i < dms_pkg::CELLS; i++) begin
			send_item(dms_pkg::OP_TARGET, dms_pkg::ATOM_W'($urandom),
				dms_pkg::ELEM_W'(order[i]), fill_value(style), i == dms_pkg::CELLS - 1);
		end
	endtask

	// One phase of random traffic. Every store entry is written by now, so any
	// search reads only defined data.
	task automatic run_phase(input int quota);
		int    roll;
		int    k;
		logic  lst;
		fill_t style;
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				send_full_target();
			end else if (roll < 70) begin
				// Partial target update; usually, not always, closed by a search.
				k = $urandom_range(1, 4);
				style = pick_fill();
				for (int i = 0; i < k; i++) begin
					lst = (i == k - 1) && ($urandom_range(0, 3) != 0);
					send_item(dms_pkg::OP_TARGET, dms_pkg::ATOM_W'($urandom),
						dms_pkg::ELEM_W'($urandom), fill_value(style), lst);
				end
			end else if (roll < 90) begin
				// Atom rewrites, mostly in the low slots that searches reach.
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					send_item(dms_pkg::OP_ATOM,
						$urandom_range(0, 1) ? dms_pkg::ATOM_W'($urandom_range(0, 7)) :
							dms_pkg::ATOM_W'($urandom),
						dms_pkg::ELEM_W'($urandom), fill_value(pick_fill()), 1'($urandom));
				end
			end else begin
				send_item(dms_pkg::OP_TARGET, dms_pkg::ATOM_W'($urandom),
					dms_pkg::ELEM_W'($urandom), fill_value(pick_fill()), 1'b0);
			end
		end
	endtask

	initial begin
		logic [dms_pkg::COUNT_W-1:0] counts[10];
		logic signed [dms_pkg::VAL_W-1:0] tv;

		counts = '{7'd1, 7'd64, 7'($urandom_range(2, 8)), 7'd0, 7'd127,
			7'($urandom_range(1, 8)), 7'd65, 7'($urandom_range(1, 8)), 7'd2, 7'd8};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. atom_count is zero after reset, so the first searches
		// have no atoms and must return atom 0, code 0 and a zero projection.
		// The target is mostly the most negative value, with the other
		// extremes mixed in, so that a later search against an all-negative
		// atom saturates.
		for (int i = 0; i < dms_pkg::CELLS; i++) begin
			case (i)
				1: tv = 16'sh7FFF;
				2: tv = 16'sd0;
				3: tv = -16'sd1;
				4: tv = 16'sd1;
				default: tv = 16'sh8000;
			endcase
			send_item(dms_pkg::OP_TARGET, dms_pkg::ATOM_W'(i * 4), dms_pkg::ELEM_W'(i), tv,
				i == dms_pkg::CELLS - 1);
		end
		// last on an atom write is ignored and causes no result.
		send_item(dms_pkg::OP_ATOM, 6'd63, 4'd15, 16'sh7FFF, 1'b1);
		// A single target write with last reruns the empty search.
		send_item(dms_pkg::OP_TARGET, 6'd0, 4'd5, 16'sh8000, 1'b1);

		// Load every atom once so that no later search reads an unwritten
		// entry. Atom 0 is all most-negative and atom 1 all zero.
		for (int a = 0; a < dms_pkg::MAX_ATOMS; a++) begin
			for (int e = 0; e < dms_pkg::CELLS; e++) begin
				if (a == 0) begin
					tv = 16'sh8000;
				end else if (a == 1) begin
					tv = 16'sd0;
				end else begin
					tv = fill_value($urandom_range(0, 3) == 0 ? FILL_EDGE : FILL_FULL);
				end
				send_item(dms_pkg::OP_ATOM, dms_pkg::ATOM_W'(a), dms_pkg::ELEM_W'(e), tv, 1'b0);
			end
		end

		// One atom against the mostly negative target: the projection saturates.
		drain();
		write_count(7'd1);
		send_item(dms_pkg::OP_TARGET, 6'd0, 4'd6, 16'sh8000, 1'b1);

		// Random phases, each under its own atom_count. Large counts make a
		// search long, so those phases stay short. The
		// last phase runs without idle or stall cycles.
		for (int p = 0; p < 10; p++) begin
			drain();
			write_count(counts[p]);
			if (p == 9) begin
				quiet = 1'b1;
			end
			run_phase(counts[p] > 8 ? 32 : 110);
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.depth() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== dictionary_match_search_core.f =====
hw/rtl/dms_pkg.sv
hw/rtl/dms_mac.sv
hw/rtl/dictionary_match_search_core.sv
tb/tb_dictionary_match_search_core.sv
